// ----- hw/rtl/xfcd_pkg.sv -----
// Shared types and constants for the frame checker with duplicate-ID filter.
package xfcd_pkg;

    // Number of ID bytes that end the payload
    localparam int unsigned ID_BYTES = 6;
    localparam int unsigned ID_W     = 48;
    localparam int unsigned POS_W    = 9;
    localparam int unsigned CFG_ADDR_W = 1;
    localparam int unsigned CFG_DATA_W = 8;
    localparam int unsigned OUT_DATA_W = 80;

    // Header register reset values
    localparam logic [7:0] HEADER_FIRST_RST  = 8'h24;
    localparam logic [7:0] HEADER_SECOND_RST = 8'h40;

    // Configuration register indexes
    localparam logic [CFG_ADDR_W-1:0] REG_HEADER_FIRST  = 1'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_HEADER_SECOND = 1'd1;

    typedef enum logic [2:0] {
        ST_NEW_VALID    = 3'd0,
        ST_DUPLICATE    = 3'd1,
        ST_BAD_HEADER   = 3'd2,
        ST_BAD_CHECKSUM = 3'd3,
        ST_BAD_LENGTH   = 3'd4
    } frame_status_t;

    // One registered input beat
    typedef struct packed {
        logic       valid;
        logic [7:0] rx_byte;
        logic       first_byte;
    } xfcd_beat_t;

    // One frame status result
    typedef struct packed {
        frame_status_t     status;
        logic [15:0]       command_code;
        logic [7:0]        length_field;
        logic [ID_W-1:0]   sequence_id;
    } xfcd_result_t;

endpackage

// ----- hw/rtl/xfcd_in_stage.sv -----
// Input register for received frame bytes.
module xfcd_in_stage (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                s_axis_tvalid,
    output logic                s_axis_tready,
    input  logic [7:0]          s_axis_tdata,   // [7:0] rx_byte
    input  logic                s_axis_tuser,   // [0] first_byte
    input  logic                take,
    output xfcd_pkg::xfcd_beat_t beat,
    output logic                proc_en
);
    import xfcd_pkg::*;

    logic       valid_reg;
    logic       valid_next;
    logic [7:0] byte_reg;
    logic       first_reg;

    // Hand the held beat on when the result side can take it
    assign proc_en       = valid_reg && take;
    assign s_axis_tready = !valid_reg || take;
    assign valid_next    = s_axis_tready ? s_axis_tvalid : valid_reg;

    // Hold the control bit
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // Capture the payload on an accepted beat
    always_ff @(posedge clk)
    begin
        if (s_axis_tvalid && s_axis_tready)
        begin
            byte_reg  <= s_axis_tdata;
            first_reg <= s_axis_tuser;
        end
    end

    assign beat.valid      = valid_reg;
    assign beat.rx_byte    = byte_reg;
    assign beat.first_byte = first_reg;

endmodule

// ----- hw/rtl/xfcd_frame_core.sv -----
// Frame parser: header check, length check, running XOR, ID capture and duplicate filter.
module xfcd_frame_core (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 cfg_we,
    input  logic [xfcd_pkg::CFG_ADDR_W-1:0]      cfg_addr,
    input  logic [xfcd_pkg::CFG_DATA_W-1:0]      cfg_wdata,
    input  xfcd_pkg::xfcd_beat_t                 beat,
    input  logic                                 proc_en,
    output logic                                 res_valid,
    output xfcd_pkg::xfcd_result_t               result
);
    import xfcd_pkg::*;

    logic [7:0]       header_first_reg;
    logic [7:0]       header_second_reg;

    logic [POS_W-1:0] byte_position_reg, byte_position_next;
    logic             frame_active_reg, frame_active_next;
    logic [7:0]       running_xor_reg, running_xor_next;
    logic [7:0]       held_length_reg, held_length_next;
    logic [15:0]      held_command_reg, held_command_next;
    logic [ID_W-1:0]  id_shift_reg, id_shift_next;
    logic [ID_W-1:0]  stored_id_reg, stored_id_next;

    // Effective state once a new-frame mark is applied
    logic             active_eff;
    logic [POS_W-1:0] pos;
    logic [7:0]       xor_eff;
    logic [7:0]       len_eff;
    logic [15:0]      cmd_eff;
    logic [ID_W-1:0]  id_eff;
    logic [POS_W:0]   end_pos;
    logic [POS_W:0]   pos_wide;
    logic [7:0]       b;

    assign b          = beat.rx_byte;
    assign active_eff = beat.first_byte || frame_active_reg;
    assign pos        = beat.first_byte ? '0 : byte_position_reg;
    assign xor_eff    = beat.first_byte ? 8'd0 : running_xor_reg;
    assign len_eff    = beat.first_byte ? 8'd0 : held_length_reg;
    assign cmd_eff    = beat.first_byte ? 16'd0 : held_command_reg;
    assign id_eff     = beat.first_byte ? '0 : id_shift_reg;
    assign end_pos    = (POS_W+1)'(len_eff) + (POS_W+1)'(5);
    assign pos_wide   = (POS_W+1)'(pos);

    // Configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            header_first_reg  <= HEADER_FIRST_RST;
            header_second_reg <= HEADER_SECOND_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_addr)
                REG_HEADER_FIRST:  header_first_reg  <= cfg_wdata;
                REG_HEADER_SECOND: header_second_reg <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // Work out the next frame state and any status for this beat
    always_comb
    begin
        byte_position_next = byte_position_reg;
        frame_active_next  = frame_active_reg;
        running_xor_next   = running_xor_reg;
        held_length_next   = held_length_reg;
        held_command_next  = held_command_reg;
        id_shift_next      = id_shift_reg;
        stored_id_next     = stored_id_reg;
        res_valid          = 1'b0;
        result.status       = ST_NEW_VALID;
        result.command_code = cmd_eff;
        result.length_field = len_eff;
        result.sequence_id  = id_eff;

        if (proc_en && active_eff)
        begin
            frame_active_next  = 1'b1;
            byte_position_next = pos + POS_W'(1);
            running_xor_next   = xor_eff;
            held_length_next   = len_eff;
            held_command_next  = cmd_eff;
            id_shift_next      = id_eff;

            if (pos == POS_W'(0) || pos == POS_W'(1))
            begin
                // Header bytes
                if ((pos == POS_W'(0) && b != header_first_reg) ||
                    (pos == POS_W'(1) && b != header_second_reg))
                begin
                    res_valid           = 1'b1;
                    result.status       = ST_BAD_HEADER;
                    result.command_code = 16'd0;
                    result.length_field = 8'd0;
                    result.sequence_id  = '0;
                    frame_active_next   = 1'b0;
                end
            end
            else if (pos == POS_W'(2))
            begin
                running_xor_next  = xor_eff ^ b;
                held_command_next = {b, 8'd0};
            end
            else if (pos == POS_W'(3))
            begin
                running_xor_next  = xor_eff ^ b;
                held_command_next = {cmd_eff[15:8], b};
            end
            else if (pos == POS_W'(4))
            begin
                running_xor_next = xor_eff ^ b;
                held_length_next = b;
                // Too short to carry the ID
                if (b < 8'(ID_BYTES))
                begin
                    res_valid           = 1'b1;
                    result.status       = ST_BAD_LENGTH;
                    result.length_field = b;
                    result.sequence_id  = '0;
                    frame_active_next   = 1'b0;
                end
            end
            else if (pos_wide < end_pos)
            begin
                running_xor_next = xor_eff ^ b;
                if (pos_wide + (POS_W+1)'(ID_BYTES) >= end_pos)
                begin
                    id_shift_next = {id_eff[ID_W-9:0], b};
                end
            end
            else
            begin
                // Checksum byte closes the frame
                res_valid         = 1'b1;
                frame_active_next = 1'b0;
                if (b != xor_eff)
                begin
                    result.status = ST_BAD_CHECKSUM;
                end
                else if (id_eff == stored_id_reg)
                begin
                    result.status = ST_DUPLICATE;
                end
                else
                begin
                    result.status  = ST_NEW_VALID;
                    stored_id_next = id_eff;
                end
            end
        end
    end

    // Frame state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            byte_position_reg <= '0;
            frame_active_reg  <= 1'b0;
            running_xor_reg   <= 8'd0;
            held_length_reg   <= 8'd0;
            held_command_reg  <= 16'd0;
            id_shift_reg      <= '0;
            stored_id_reg     <= '0;
        end
        else
        begin
            byte_position_reg <= byte_position_next;
            frame_active_reg  <= frame_active_next;
            running_xor_reg   <= running_xor_next;
            held_length_reg   <= held_length_next;
            held_command_reg  <= held_command_next;
            id_shift_reg      <= id_shift_next;
            stored_id_reg     <= stored_id_next;
        end
    end

endmodule

// ----- hw/rtl/xfcd_out_stage.sv -----
// Result register driving the status stream.
module xfcd_out_stage (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  proc_en,
    input  logic                                  res_valid,
    input  xfcd_pkg::xfcd_result_t                result,
    output logic                                  take,
    output logic                                  m_axis_tvalid,
    input  logic                                  m_axis_tready,
    // [2:0] frame_status, [18:3] command_code, [26:19] length_field,
    // [74:27] sequence_id, [79:75] zero
    output logic [xfcd_pkg::OUT_DATA_W-1:0]       m_axis_tdata
);
    import xfcd_pkg::*;

    localparam int unsigned RES_W = $bits(xfcd_result_t);

    logic              valid_reg;
    logic              valid_next;
    logic [RES_W-1:0]  data_reg;
    xfcd_result_t      held;

    // Free when empty or when the held result leaves this cycle
    assign take = !valid_reg || m_axis_tready;

    always_comb
    begin
        valid_next = valid_reg;
        if (proc_en)
        begin
            valid_next = res_valid;
        end
        else if (m_axis_tready)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // Load the payload with each new status
    always_ff @(posedge clk)
    begin
        if (proc_en && res_valid)
        begin
            data_reg <= result;
        end
    end

    assign held          = xfcd_result_t'(data_reg);
    assign m_axis_tvalid = valid_reg;
    assign m_axis_tdata  = {(OUT_DATA_W-RES_W)'(0), held.sequence_id, held.length_field,
                            held.command_code, held.status};

endmodule

// ----- hw/rtl/xor_frame_checker_dedup_top.sv -----
// A byte accepted into the input register is parsed once the result side can take it, and any status
// it yields loads the result register, which holds m_axis_tvalid high until the status beat is taken.
// Throughput: one received byte per cycle; an untaken status stalls s_axis_tready once the
// input register is also full, and each frame parse step is combinational logic.
// At most one status beat per frame, on its last checked byte.
// Reset (rst_n low, asynchronous): headers return to 0x24 and 0x40, no frame is active,
// the stored ID clears to zero and both stream registers empty.
module xor_frame_checker_dedup_top (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  cfg_we,
    input  logic [xfcd_pkg::CFG_ADDR_W-1:0]       cfg_addr,
    input  logic [xfcd_pkg::CFG_DATA_W-1:0]       cfg_wdata,
    input  logic                                  s_axis_tvalid,
    output logic                                  s_axis_tready,
    input  logic [7:0]                            s_axis_tdata,   // [7:0] rx_byte
    input  logic                                  s_axis_tuser,   // [0] first_byte
    output logic                                  m_axis_tvalid,
    input  logic                                  m_axis_tready,
    // [2:0] frame_status, [18:3] command_code, [26:19] length_field,
    // [74:27] sequence_id, [79:75] zero
    output logic [xfcd_pkg::OUT_DATA_W-1:0]       m_axis_tdata
);
    import xfcd_pkg::*;

    xfcd_beat_t   beat;
    xfcd_result_t result;
    logic         proc_en;
    logic         take;
    logic         res_valid;

    xfcd_in_stage u_in (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .take          (take),
        .beat          (beat),
        .proc_en       (proc_en)
    );

    xfcd_frame_core u_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .beat      (beat),
        .proc_en   (proc_en),
        .res_valid (res_valid),
        .result    (result)
    );

    xfcd_out_stage u_out (
        .clk           (clk),
        .rst_n         (rst_n),
        .proc_en       (proc_en),
        .res_valid     (res_valid),
        .result        (result),
        .take          (take),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

endmodule
